### rtl/tawad_pkg.sv
// shared constants, types and axis codes for the three-axis window average
// no dependencies
package tawad_pkg;

  localparam int WINDOW      = 16;
  localparam int WIN_BITS    = $clog2(WINDOW);
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = SAMPLE_BITS + WIN_BITS;
  localparam int FILL_W      = WIN_BITS + 1;

  typedef enum logic [2:0] {
    AX_PX = 3'd0,
    AX_NX = 3'd1,
    AX_PY = 3'd2,
    AX_NY = 3'd3,
    AX_PZ = 3'd4,
    AX_NZ = 3'd5
  } axis_t;

  // control that travels with one request from the sum stage to the merge stage
  typedef struct packed {
    logic valid;
    logic avg_valid;
    logic active;
    logic clear;
  } s1_ctrl_t;

endpackage

### rtl/tawad_lane.sv
// one axis lane: ring of WINDOW samples and the running window sum
// depends on tawad_pkg
module tawad_lane
  import tawad_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          add,
  input  logic                          clear,
  input  logic                          full,
  input  logic [WIN_BITS-1:0]           wpos,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SUM_W-1:0]       sum
);

  logic signed [SAMPLE_BITS-1:0] ring_r [WINDOW];
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic signed [SUM_W-1:0]       old_ext;

  // oldest entry drops out only once the window has filled
  assign old_ext = full ? SUM_W'(ring_r[wpos]) : '0;

  always_comb begin
    sum_nxt = sum_r;
    if (clear) begin
      sum_nxt = '0;
    end else if (add) begin
      sum_nxt = sum_r - old_ext + SUM_W'(sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (add) begin
      ring_r[wpos] <= sample;
    end
  end

  assign sum = sum_r;

endmodule

### rtl/tawad_merge.sv
// merge stage: averages from the three lane sums, dominant axis pick,
// axis change and led tracking, output register; depends on tawad_pkg
module tawad_merge
  import tawad_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  s1_ctrl_t                      s1,
  input  logic signed [SUM_W-1:0]       sum_x,
  input  logic signed [SUM_W-1:0]       sum_y,
  input  logic signed [SUM_W-1:0]       sum_z,
  output logic                          out_valid,
  output logic                          avg_valid,
  output logic signed [SAMPLE_BITS-1:0] avg_x,
  output logic signed [SAMPLE_BITS-1:0] avg_y,
  output logic signed [SAMPLE_BITS-1:0] avg_z,
  output logic [2:0]                    dominant_axis,
  output logic                          axis_changed,
  output logic                          green_led,
  output logic                          payload_active
);

  logic signed [SAMPLE_BITS-1:0] ax, ay, az;
  logic [SAMPLE_BITS:0]          mx, my, mz;
  axis_t                         pick;
  axis_t                         axis_nxt;
  axis_t                         last_axis_r;
  logic                          green_r, green_nxt;
  logic                          changed_nxt;

  logic                          out_valid_r;
  logic                          avg_valid_r;
  logic signed [SAMPLE_BITS-1:0] avg_x_r, avg_y_r, avg_z_r;
  axis_t                         axis_r;
  logic                          changed_r;
  logic                          active_r;

  // floor of sum / WINDOW is an arithmetic shift
  assign ax = sum_x[SUM_W-1:WIN_BITS];
  assign ay = sum_y[SUM_W-1:WIN_BITS];
  assign az = sum_z[SUM_W-1:WIN_BITS];

  assign mx = ax[SAMPLE_BITS-1] ? -{ax[SAMPLE_BITS-1], ax} : {ax[SAMPLE_BITS-1], ax};
  assign my = ay[SAMPLE_BITS-1] ? -{ay[SAMPLE_BITS-1], ay} : {ay[SAMPLE_BITS-1], ay};
  assign mz = az[SAMPLE_BITS-1] ? -{az[SAMPLE_BITS-1], az} : {az[SAMPLE_BITS-1], az};

  // ties favor x, then y
  always_comb begin
    if (mx >= my && mx >= mz) begin
      pick = ax[SAMPLE_BITS-1] ? AX_NX : AX_PX;
    end else if (my >= mz) begin
      pick = ay[SAMPLE_BITS-1] ? AX_NY : AX_PY;
    end else begin
      pick = az[SAMPLE_BITS-1] ? AX_NZ : AX_PZ;
    end
  end

  always_comb begin
    axis_nxt    = last_axis_r;
    green_nxt   = green_r;
    changed_nxt = 1'b0;
    if (s1.clear) begin
      green_nxt = 1'b0;
    end else if (s1.avg_valid) begin
      axis_nxt    = pick;
      changed_nxt = (pick != last_axis_r);
      green_nxt   = (pick == AX_PZ) || (pick == AX_NZ);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_axis_r <= AX_PZ;
      green_r     <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1.valid;
      if (s1.valid) begin
        last_axis_r <= axis_nxt;
        green_r     <= green_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1.valid) begin
      avg_valid_r <= s1.avg_valid;
      avg_x_r     <= s1.avg_valid ? ax : '0;
      avg_y_r     <= s1.avg_valid ? ay : '0;
      avg_z_r     <= s1.avg_valid ? az : '0;
      axis_r      <= axis_nxt;
      changed_r   <= changed_nxt;
      active_r    <= s1.active;
    end
  end

  assign out_valid      = out_valid_r;
  assign avg_valid      = avg_valid_r;
  assign avg_x          = avg_x_r;
  assign avg_y          = avg_y_r;
  assign avg_z          = avg_z_r;
  assign dominant_axis  = axis_r;
  assign axis_changed   = changed_r;
  assign green_led      = green_r;
  assign payload_active = active_r;

endmodule

### rtl/three_axis_window_average_dominant_top.sv
// Three-axis boxcar moving average with dominant-axis detection. One request
// is taken per clock cycle, back to back, unless a result is held at the
// output with the stage register full; each request gives exactly one result.
// On acceptance the three axis lanes write their ring entry, update their
// running sums and the control is registered; the merge stage then forms the
// averages (sum shifted right by log2 of the window), picks the dominant
// signed axis and loads the output register once free. A power-off
// request clears the window; ring contents are never read before written.
// depends on tawad_pkg, tawad_lane, tawad_merge
module three_axis_window_average_dominant_top
  import tawad_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_z,
  input  logic                          in_power_on,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_avg_valid,
  output logic signed [SAMPLE_BITS-1:0] out_avg_x,
  output logic signed [SAMPLE_BITS-1:0] out_avg_y,
  output logic signed [SAMPLE_BITS-1:0] out_avg_z,
  output logic [2:0]                    out_dominant_axis,
  output logic                          out_axis_changed,
  output logic                          out_green_led,
  output logic                          out_payload_active
);

  logic                active_r, active_nxt;
  logic [WIN_BITS-1:0] wpos_r, wpos_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  s1_ctrl_t            s1_r, s1_nxt;
  logic                accept, add, clear, full, en;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;

  assign en       = ~out_valid | out_ready;
  assign in_ready = en | ~s1_r.valid;
  assign accept   = in_valid & in_ready;
  assign add      = accept & ~in_cmd & active_r;
  assign clear    = accept & in_cmd & ~in_power_on;
  assign full     = (fill_r == FILL_W'(WINDOW));

  always_comb begin
    active_nxt = active_r;
    wpos_nxt   = wpos_r;
    fill_nxt   = fill_r;
    if (accept && in_cmd) begin
      active_nxt = in_power_on;
      if (!in_power_on) begin
        wpos_nxt = '0;
        fill_nxt = '0;
      end
    end else if (add) begin
      wpos_nxt = wpos_r + 1'b1;
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_nxt = s1_r;
    if (accept) begin
      s1_nxt.valid     = 1'b1;
      s1_nxt.avg_valid = add && (fill_nxt == FILL_W'(WINDOW));
      s1_nxt.active    = active_nxt;
      s1_nxt.clear     = clear;
    end else if (en) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      wpos_r   <= '0;
      fill_r   <= '0;
      s1_r     <= '0;
    end else begin
      active_r <= active_nxt;
      wpos_r   <= wpos_nxt;
      fill_r   <= fill_nxt;
      s1_r     <= s1_nxt;
    end
  end

  tawad_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .add    (add),
    .clear  (clear),
    .full   (full),
    .wpos   (wpos_r),
    .sample (in_sample_x),
    .sum    (sum_x)
  );

  tawad_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .add    (add),
    .clear  (clear),
    .full   (full),
    .wpos   (wpos_r),
    .sample (in_sample_y),
    .sum    (sum_y)
  );

  tawad_lane u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .add    (add),
    .clear  (clear),
    .full   (full),
    .wpos   (wpos_r),
    .sample (in_sample_z),
    .sum    (sum_z)
  );

  tawad_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .s1             (s1_r),
    .sum_x          (sum_x),
    .sum_y          (sum_y),
    .sum_z          (sum_z),
    .out_valid      (out_valid),
    .avg_valid      (out_avg_valid),
    .avg_x          (out_avg_x),
    .avg_y          (out_avg_y),
    .avg_z          (out_avg_z),
    .dominant_axis  (out_dominant_axis),
    .axis_changed   (out_axis_changed),
    .green_led      (out_green_led),
    .payload_active (out_payload_active)
  );

endmodule

### verif/three_axis_window_average_dominant_top_tb.sv
// testbench for the three-axis window average with dominant-axis pick
// depends on tawad_pkg and three_axis_window_average_dominant_top
// directed table first, then random request streams checked by an in-bench predictor
`timescale 1ns / 100ps

module three_axis_window_average_dominant_top_tb;
  import tawad_pkg::*;

  localparam int MODE_WIDE = 0;
  localparam int MODE_TINY = 1;
  localparam int MODE_EXTREME = 2;
  localparam int MODE_MID = 3;
  localparam int RANDOM_REQUESTS = 1400;
  localparam int LONG_HOLD_CYCLES = 120;

  typedef struct {
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic                          power_on;
  } accel_request_t;

  typedef struct {
    logic                          avg_valid;
    logic signed [SAMPLE_BITS-1:0] avg_x;
    logic signed [SAMPLE_BITS-1:0] avg_y;
    logic signed [SAMPLE_BITS-1:0] avg_z;
    axis_t                         axis;
    logic                          changed;
    logic                          green;
    logic                          active;
  } avg_result_t;

  typedef struct {
    accel_request_t req;
    bit             typed;
    avg_result_t    res;
  } dir_row_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_cmd = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_sample_x = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_y = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_z = '0;
  logic                          in_power_on = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_avg_valid;
  logic signed [SAMPLE_BITS-1:0] out_avg_x;
  logic signed [SAMPLE_BITS-1:0] out_avg_y;
  logic signed [SAMPLE_BITS-1:0] out_avg_z;
  logic [2:0]                    out_dominant_axis;
  logic                          out_axis_changed;
  logic                          out_green_led;
  logic                          out_payload_active;

  // predictor state
  logic                          win_active;
  logic signed [SAMPLE_BITS-1:0] win_ring_x [WINDOW];
  logic signed [SAMPLE_BITS-1:0] win_ring_y [WINDOW];
  logic signed [SAMPLE_BITS-1:0] win_ring_z [WINDOW];
  logic [WIN_BITS-1:0]           win_pos;
  logic [FILL_W-1:0]             win_fill;
  logic signed [SUM_W-1:0]       win_sum_x;
  logic signed [SUM_W-1:0]       win_sum_y;
  logic signed [SUM_W-1:0]       win_sum_z;
  axis_t                         win_last_axis;
  logic                          win_green;

  avg_result_t pending_results [$];
  dir_row_t    directed_rows [$];
  int          fail_count = 0;
  int          results_checked = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  three_axis_window_average_dominant_top i_dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic avg_result_t window_average_step(accel_request_t req);
    avg_result_t                   res;
    logic signed [SAMPLE_BITS-1:0] ax, ay, az;
    int                            mx, my, mz;
    res = '{1'b0, '0, '0, '0, win_last_axis, 1'b0, 1'b0, 1'b0};
    if (req.cmd) begin
      win_active = req.power_on;
      if (!req.power_on) begin
        win_pos = '0;
        win_fill = '0;
        win_sum_x = '0;
        win_sum_y = '0;
        win_sum_z = '0;
        win_green = 1'b0;
      end
    end else if (win_active) begin
      // oldest entry leaves the sums only once the window has been filled
      if (win_fill == WINDOW) begin
        win_sum_x = win_sum_x - SUM_W'(win_ring_x[win_pos]);
        win_sum_y = win_sum_y - SUM_W'(win_ring_y[win_pos]);
        win_sum_z = win_sum_z - SUM_W'(win_ring_z[win_pos]);
      end
      win_ring_x[win_pos] = req.sample_x;
      win_ring_y[win_pos] = req.sample_y;
      win_ring_z[win_pos] = req.sample_z;
      win_sum_x = win_sum_x + SUM_W'(req.sample_x);
      win_sum_y = win_sum_y + SUM_W'(req.sample_y);
      win_sum_z = win_sum_z + SUM_W'(req.sample_z);
      win_pos = win_pos + 1'b1;
      if (win_fill < WINDOW) win_fill = win_fill + 1'b1;
      if (win_fill == WINDOW) begin
        ax = SAMPLE_BITS'(win_sum_x >>> WIN_BITS);
        ay = SAMPLE_BITS'(win_sum_y >>> WIN_BITS);
        az = SAMPLE_BITS'(win_sum_z >>> WIN_BITS);
        mx = int'(ax);
        my = int'(ay);
        mz = int'(az);
        if (mx < 0) mx = -mx;
        if (my < 0) my = -my;
        if (mz < 0) mz = -mz;
        // ties go to x, then y; zero counts as positive
        if (mx >= my && mx >= mz) res.axis = (ax < 0) ? AX_NX : AX_PX;
        else if (my >= mz) res.axis = (ay < 0) ? AX_NY : AX_PY;
        else res.axis = (az < 0) ? AX_NZ : AX_PZ;
        res.avg_valid = 1'b1;
        res.avg_x = ax;
        res.avg_y = ay;
        res.avg_z = az;
        res.changed = (res.axis != win_last_axis);
        win_last_axis = res.axis;
        win_green = (res.axis == AX_PZ || res.axis == AX_NZ);
      end
    end
    res.green = win_green;
    res.active = win_active;
    return res;
  endfunction

  function automatic avg_result_t no_avg(axis_t axis, logic green, logic active);
    return '{1'b0, '0, '0, '0, axis, 1'b0, green, active};
  endfunction

  function automatic dir_row_t drow(logic cmd, logic pwr, logic [SAMPLE_BITS-1:0] x,
                                    logic [SAMPLE_BITS-1:0] y, logic [SAMPLE_BITS-1:0] z,
                                    bit typed, avg_result_t res);
    dir_row_t row;
    row.req = '{cmd, x, y, z, pwr};
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(int mode);
    logic [SAMPLE_BITS-1:0] v;
    case (mode)
      MODE_TINY: v = SAMPLE_BITS'($urandom_range(0, 4) - 2);
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = 16'h8001;
        endcase
      end
      MODE_MID: v = SAMPLE_BITS'($urandom_range(0, 2048) - 1024);
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_request(accel_request_t req, bit typed, avg_result_t typed_res);
    int          gap;
    avg_result_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= req.cmd;
    in_sample_x <= req.sample_x;
    in_sample_y <= req.sample_y;
    in_sample_z <= req.sample_z;
    in_power_on <= req.power_on;
    do @(posedge clk); while (!in_ready);
    predicted = window_average_step(req);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic compare_field(string name, logic [SAMPLE_BITS-1:0] want,
                               logic [SAMPLE_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result side: random stalls, one long hold-off, check on every accepted result
  initial begin
    int          stall;
    bit          held;
    avg_result_t want;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 3);
      if (!held && results_checked >= 400) begin
        held = 1'b1;
        stall = LONG_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual axis %h",
                 $time, out_dominant_axis);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("avg_valid", SAMPLE_BITS'(want.avg_valid), SAMPLE_BITS'(out_avg_valid));
        compare_field("avg_x", want.avg_x, out_avg_x);
        compare_field("avg_y", want.avg_y, out_avg_y);
        compare_field("avg_z", want.avg_z, out_avg_z);
        compare_field("dominant_axis", SAMPLE_BITS'(want.axis),
                      SAMPLE_BITS'(out_dominant_axis));
        compare_field("axis_changed", SAMPLE_BITS'(want.changed),
                      SAMPLE_BITS'(out_axis_changed));
        compare_field("green_led", SAMPLE_BITS'(want.green), SAMPLE_BITS'(out_green_led));
        compare_field("payload_active", SAMPLE_BITS'(want.active),
                      SAMPLE_BITS'(out_payload_active));
      end
      results_checked++;
      if (results_checked % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    accel_request_t req;
    avg_result_t    none;
    int             taken;
    int             seg_left;
    int             mode;
    int             r;
    bit             was_active;
    bit             paused;

    win_active = 1'b0;
    win_pos = '0;
    win_fill = '0;
    win_sum_x = '0;
    win_sum_y = '0;
    win_sum_z = '0;
    win_last_axis = AX_PZ;
    win_green = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      win_ring_x[i] = '0;
      win_ring_y[i] = '0;
      win_ring_z[i] = '0;
    end
    none = no_avg(AX_PZ, 1'b0, 1'b0);

    // sample while off, off while off, on, on while on
    directed_rows.push_back(drow(1'b0, 1'b1, 16'h0001, 16'h0002, 16'h0003, 1'b1,
                                 no_avg(AX_PZ, 1'b0, 1'b0)));
    directed_rows.push_back(drow(1'b1, 1'b0, 16'h1234, 16'h8000, 16'h7fff, 1'b1,
                                 no_avg(AX_PZ, 1'b0, 1'b0)));
    directed_rows.push_back(drow(1'b1, 1'b1, 16'hffff, 16'h0000, 16'h8000, 1'b1,
                                 no_avg(AX_PZ, 1'b0, 1'b1)));
    directed_rows.push_back(drow(1'b1, 1'b1, 16'h0000, 16'hffff, 16'h0000, 1'b1,
                                 no_avg(AX_PZ, 1'b0, 1'b1)));
    // fill the window with extremes; the last one reports -x by one count of magnitude
    for (int i = 0; i < WINDOW - 1; i++)
      directed_rows.push_back(drow(1'b0, 1'b0, 16'h8000, 16'h7fff, 16'h0000, 1'b1,
                                   no_avg(AX_PZ, 1'b0, 1'b1)));
    directed_rows.push_back(drow(1'b0, 1'b1, 16'h8000, 16'h7fff, 16'h0000, 1'b1,
                                 '{1'b1, 16'sh8000, 16'sh7fff, 16'sh0000, AX_NX,
                                   1'b1, 1'b0, 1'b1}));
    // eviction, then off with the last axis kept, then refill starts again
    directed_rows.push_back(drow(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h8000, 1'b0, none));
    directed_rows.push_back(drow(1'b0, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, none));
    directed_rows.push_back(drow(1'b1, 1'b0, 16'h5555, 16'haaaa, 16'h0f0f, 1'b0, none));
    directed_rows.push_back(drow(1'b1, 1'b1, 16'haaaa, 16'h5555, 16'hf0f0, 1'b0, none));
    directed_rows.push_back(drow(1'b0, 1'b0, 16'h0010, 16'hfff0, 16'h0020, 1'b0, none));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    taken = 0;
    seg_left = 0;
    mode = MODE_WIDE;
    paused = 1'b0;
    while (taken < RANDOM_REQUESTS) begin
      if (seg_left == 0) begin
        mode = $urandom_range(MODE_WIDE, MODE_MID);
        seg_left = $urandom_range(10, 60);
        send_burst = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      // let the whole pipeline drain once before carrying on
      if (!paused && taken == RANDOM_REQUESTS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      req.cmd = 1'b0;
      req.power_on = 1'($urandom);
      req.sample_x = draw_sample(mode);
      req.sample_y = draw_sample(mode);
      req.sample_z = draw_sample(mode);
      r = $urandom_range(0, 99);
      was_active = win_active;
      if (!win_active) begin
        // mostly switch back on; the rest are samples that must be ignored
        if (r < 85) begin
          req.cmd = 1'b1;
          req.power_on = 1'b1;
        end
      end else if (r < 2) begin
        req.cmd = 1'b1;
        req.power_on = 1'b0;
      end else if (r < 4) begin
        req.cmd = 1'b1;
        req.power_on = 1'b1;
      end
      send_request(req, 1'b0, none);
      if (req.cmd || was_active) taken++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
